// File: src/apc_pkg.sv
`timescale 1ns / 1ps

package apc_pkg;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } apc_in_t;

    typedef struct packed {
        logic [1:0] device_class;
        logic [1:0] tool_variant;
    } apc_out_t;

    typedef enum logic [1:0] {
        PH_LENGTH,
        PH_TYPE,
        PH_DATA,
        PH_STOP
    } parse_phase_t;

    // Tool variant codes, also stored as the best match found so far.
    localparam logic [1:0] VAR_NONE = 2'd0;
    localparam logic [1:0] VAR_3082 = 2'd1;
    localparam logic [1:0] VAR_3081 = 2'd2;
    localparam logic [1:0] VAR_3083 = 2'd3;

    localparam logic [1:0] CLASS_NONE    = 2'd0;
    localparam logic [1:0] CLASS_TOOL    = 2'd1;
    localparam logic [1:0] CLASS_TRACKER = 2'd2;
    localparam logic [1:0] CLASS_PROX    = 2'd3;

    localparam logic [15:0] UUID_3082 = 16'h3082;
    localparam logic [15:0] UUID_3081 = 16'h3081;
    localparam logic [15:0] UUID_3083 = 16'h3083;

    localparam logic [7:0] AD_UUID16_INC  = 8'h02;
    localparam logic [7:0] AD_UUID16_CMP  = 8'h03;
    localparam logic [7:0] AD_UUID32_INC  = 8'h04;
    localparam logic [7:0] AD_UUID32_CMP  = 8'h05;
    localparam logic [7:0] AD_UUID128_INC = 8'h06;
    localparam logic [7:0] AD_UUID128_CMP = 8'h07;
    localparam logic [7:0] AD_MANUF       = 8'hFF;

    localparam logic [7:0] COMPANY_LO   = 8'h4C;
    localparam logic [7:0] COMPANY_HI   = 8'h00;
    localparam logic [7:0] MSG_TRACKER  = 8'h12;
    localparam logic [7:0] MSG_PROX     = 8'h07;
    localparam logic [7:0] MANUF_MIN_LEN = 8'd4;

    function automatic logic [1:0] uuid_code(input logic [15:0] uuid);
        logic [1:0] code;
        code = VAR_NONE;
        if (uuid == UUID_3082) begin
            code = VAR_3082;
        end else if (uuid == UUID_3081) begin
            code = VAR_3081;
        end else if (uuid == UUID_3083) begin
            code = VAR_3083;
        end
        return code;
    endfunction

    // 0x3082 ranks highest, then 0x3083, then 0x3081.
    function automatic logic outranks(input logic [1:0] cand, input logic [1:0] held);
        logic res;
        res = (cand != VAR_NONE) &&
              ((held == VAR_NONE) || (cand == VAR_3082) ||
               ((cand == VAR_3083) && (held == VAR_3081)));
        return res;
    endfunction

endpackage

// File: src/adv_payload_classifier_unit.sv
`timescale 1ns / 1ps

// Advertising payload classifier.
// The s_ channel carries one payload byte per beat, with last_byte set on the
// final byte of a payload. The m_ channel carries one result beat per payload
// (device class and tool variant), and nothing for the other bytes.
// Each byte updates the parse state in the cycle it is accepted, so the block
// takes one byte every cycle while s_ready is high, with no gaps between payloads. The
// result is registered and appears on m_valid in the cycle after the last byte is taken.
// After the last byte the parse state returns to its reset value, so the next
// payload may start in the very next cycle.
// If the receiver stalls, the result is held in the output register; bytes
// that are not the last of a payload are still taken, and s_ready drops only
// for a last byte that would need the occupied output register.
// Reset (aresetn low at a clock edge) empties the output register and returns
// the parser to expecting a length byte.
module adv_payload_classifier_unit
    import apc_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  apc_in_t  s_data,
    output logic     m_valid,
    input  logic     m_ready,
    output apc_out_t m_data
);

    parse_phase_t phase_reg, phase_next;
    logic [7:0] len_reg, len_next;
    logic [7:0] type_reg, type_next;
    logic [7:0] seen_reg, seen_next;
    logic [7:0] prev_reg, prev_next;
    logic [1:0] committed_reg, committed_next;
    logic [1:0] svar_reg, svar_next;
    logic [1:0] chunk_reg, chunk_next;
    logic       long_done_reg, long_done_next;
    logic       cmatch_reg, cmatch_next;
    logic       vfound_reg, vfound_next;
    logic [7:0] vmsg_reg, vmsg_next;
    logic       m_valid_reg, m_valid_next;
    apc_out_t   m_data_reg, m_data_next;

    logic       s_fire;
    logic       finish;
    logic [7:0] b;
    logic [1:0] code;

    assign s_ready = !m_valid_reg || m_ready || !s_data.last_byte;
    assign s_fire  = s_valid && s_ready;
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;
    assign b       = s_data.data_byte;
    assign code    = uuid_code({b, prev_reg});

    always_comb begin
        phase_next     = phase_reg;
        len_next       = len_reg;
        type_next      = type_reg;
        seen_next      = seen_reg;
        prev_next      = prev_reg;
        committed_next = committed_reg;
        svar_next      = svar_reg;
        chunk_next     = chunk_reg;
        long_done_next = long_done_reg;
        cmatch_next    = cmatch_reg;
        vfound_next    = vfound_reg;
        vmsg_next      = vmsg_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        m_data_next    = m_data_reg;
        finish         = 1'b0;

        if (s_fire) begin
            unique case (phase_reg)
                PH_LENGTH: begin
                    if (b == 8'd0) begin
                        phase_next = PH_STOP;
                    end else begin
                        len_next       = b;
                        seen_next      = 8'd0;
                        svar_next      = VAR_NONE;
                        chunk_next     = VAR_NONE;
                        long_done_next = 1'b0;
                        cmatch_next    = 1'b0;
                        phase_next     = PH_TYPE;
                    end
                end
                PH_TYPE: begin
                    type_next = b;
                    if (len_reg == 8'd1) begin
                        finish = 1'b1;
                    end else begin
                        phase_next = PH_DATA;
                    end
                end
                PH_DATA: begin
                    case (type_reg) inside
                        AD_UUID16_INC, AD_UUID16_CMP: begin
                            if (seen_reg[0] && outranks(code, svar_reg)) begin
                                svar_next = code;
                            end
                        end
                        AD_UUID32_INC, AD_UUID32_CMP: begin
                            // The low half of each 32-bit entry sits in its first two bytes.
                            if (seen_reg[1:0] == 2'd1) begin
                                chunk_next = code;
                            end else if (seen_reg[1:0] == 2'd3 &&
                                         outranks(chunk_reg, svar_reg)) begin
                                svar_next = chunk_reg;
                            end
                        end
                        AD_UUID128_INC, AD_UUID128_CMP: begin
                            if (seen_reg[3:0] == 4'd0) begin
                                chunk_next = VAR_NONE;
                            end else if (chunk_reg == VAR_NONE) begin
                                chunk_next = code;
                            end
                            if (seen_reg[3:0] == 4'd15 && !long_done_reg &&
                                chunk_next != VAR_NONE) begin
                                svar_next      = chunk_next;
                                long_done_next = 1'b1;
                            end
                        end
                        AD_MANUF: begin
                            if (seen_reg == 8'd0) begin
                                cmatch_next = (b == COMPANY_LO);
                            end else if (seen_reg == 8'd1 && b != COMPANY_HI) begin
                                cmatch_next = 1'b0;
                            end else if (seen_reg == 8'd2 && !vfound_reg) begin
                                vmsg_next = b;
                            end
                        end
                        default: begin
                        end
                    endcase
                    prev_next = b;
                    seen_next = seen_reg + 8'd1;
                    if ({1'b0, seen_reg} + 9'd2 >= {1'b0, len_reg}) begin
                        finish = 1'b1;
                    end
                end
                PH_STOP: begin
                end
                default: begin
                end
            endcase

            if (finish) begin
                if (outranks(svar_next, committed_reg)) begin
                    committed_next = svar_next;
                end
                if (type_next == AD_MANUF && !vfound_reg && cmatch_next &&
                    len_reg >= MANUF_MIN_LEN) begin
                    vfound_next = 1'b1;
                end
                phase_next = PH_LENGTH;
            end

            if (s_data.last_byte) begin
                m_valid_next = 1'b1;
                m_data_next.tool_variant = VAR_NONE;
                if (committed_next != VAR_NONE) begin
                    m_data_next.device_class = CLASS_TOOL;
                    m_data_next.tool_variant = committed_next;
                end else if (vfound_next && vmsg_next == MSG_TRACKER) begin
                    m_data_next.device_class = CLASS_TRACKER;
                end else if (vfound_next && vmsg_next == MSG_PROX) begin
                    m_data_next.device_class = CLASS_PROX;
                end else begin
                    m_data_next.device_class = CLASS_NONE;
                end

                // The payload is finished: start the next one from a clean state.
                phase_next     = PH_LENGTH;
                len_next       = 8'd0;
                type_next      = 8'd0;
                seen_next      = 8'd0;
                prev_next      = 8'd0;
                committed_next = VAR_NONE;
                svar_next      = VAR_NONE;
                chunk_next     = VAR_NONE;
                long_done_next = 1'b0;
                cmatch_next    = 1'b0;
                vfound_next    = 1'b0;
                vmsg_next      = 8'd0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= PH_LENGTH;
            len_reg       <= 8'd0;
            type_reg      <= 8'd0;
            seen_reg      <= 8'd0;
            prev_reg      <= 8'd0;
            committed_reg <= VAR_NONE;
            svar_reg      <= VAR_NONE;
            chunk_reg     <= VAR_NONE;
            long_done_reg <= 1'b0;
            cmatch_reg    <= 1'b0;
            vfound_reg    <= 1'b0;
            vmsg_reg      <= 8'd0;
            m_valid_reg   <= 1'b0;
        end else begin
            phase_reg     <= phase_next;
            len_reg       <= len_next;
            type_reg      <= type_next;
            seen_reg      <= seen_next;
            prev_reg      <= prev_next;
            committed_reg <= committed_next;
            svar_reg      <= svar_next;
            chunk_reg     <= chunk_next;
            long_done_reg <= long_done_next;
            cmatch_reg    <= cmatch_next;
            vfound_reg    <= vfound_next;
            vmsg_reg      <= vmsg_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
    end

endmodule

// File: src/apc_checker.sv
`timescale 1ns / 1ps

module apc_checker
    import apc_pkg::*;
(
    input logic     aclk,
    input logic     aresetn,
    input logic     s_valid,
    input logic     s_ready,
    input apc_in_t  s_data,
    input logic     m_valid,
    input logic     m_ready,
    input apc_out_t m_data
);

    // A stalled result beat must hold.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result beat changed while stalled");

    // Every last byte taken produces a result beat in the next cycle.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_data.last_byte |=> m_valid)
        else $error("no result after the last byte of a payload");

    // A result beat only appears after the last byte of a payload.
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(s_valid && s_ready && s_data.last_byte))
        else $error("result beat without a finished payload");

    // A tool variant is reported exactly when the class is the tool class.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> ((m_data.device_class == CLASS_TOOL) ==
                     (m_data.tool_variant != VAR_NONE)))
        else $error("tool variant does not agree with device class");

endmodule

bind adv_payload_classifier_unit apc_checker u_apc_checker (.*);
